/* rtl/core/ptss_pkg.sv */
// ----------------------------------------------------------------------------
// ptss_pkg: shared types for the periodic task slot scheduler
// Command codes, sequencer states, slot unit operations and the small
// structs that pass between the sequencer and the slot file.
// ----------------------------------------------------------------------------
package ptss_pkg;

   localparam int CMD_W   = 3;
   localparam int SLOT_W  = 3;
   localparam int IVAL_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK         = 3'd0,
      CMD_ARM_PERIODIC = 3'd1,
      CMD_ARM_ONE_SHOT = 3'd2,
      CMD_DISABLE      = 3'd3,
      CMD_DISPATCH     = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_TICK     = 3'd1,
      OP_ARM      = 3'd2,
      OP_DISABLE  = 3'd3,
      OP_DISPATCH = 3'd4
   } op_type;

   // operation applied to the slot selected by the sequencer this cycle
   typedef struct packed {
      op_type op;
      logic   one_shot;
   } unit_ctl_type;

   // finished item, as handed to the response register
   typedef struct packed {
      logic              valid;
      logic              granted;
      logic [SLOT_W-1:0] slot;
   } done_type;

endpackage

/* rtl/core/ptss_slot_file.sv */
// ----------------------------------------------------------------------------
// ptss_slot_file: slot state and the shared update unit
// Holds per-slot enable, mode, reload, countdown and pending count. One slot
// is read and rewritten per cycle through a single decrement/compare unit.
// ----------------------------------------------------------------------------
module ptss_slot_file import ptss_pkg::*; #(
   parameter int SLOTS      = 8,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_ctl_type          ctl,
   input  logic [IDX_W-1:0]      idx,
   input  logic [COUNT_BITS-1:0] interval,
   output logic                  hit
);

   logic                  enabled_ff  [SLOTS];
   logic                  one_shot_ff [SLOTS];
   logic [COUNT_BITS-1:0] reload_ff   [SLOTS];
   logic [COUNT_BITS-1:0] remain_ff   [SLOTS];
   logic [COUNT_BITS-1:0] pending_ff  [SLOTS];

   logic                  cur_en;
   logic                  cur_one_shot;
   logic [COUNT_BITS-1:0] cur_reload;
   logic [COUNT_BITS-1:0] cur_remain;
   logic [COUNT_BITS-1:0] cur_pending;
   logic [COUNT_BITS-1:0] remain_dec;
   logic                  fire;
   logic                  pend_full;

   assign cur_en       = enabled_ff[idx];
   assign cur_one_shot = one_shot_ff[idx];
   assign cur_reload   = reload_ff[idx];
   assign cur_remain   = remain_ff[idx];
   assign cur_pending  = pending_ff[idx];

   // shared unit: wrap-around decrement and zero detect
   assign remain_dec = cur_remain - {{(COUNT_BITS-1){1'b0}}, 1'b1};
   assign fire       = (remain_dec == '0);
   assign pend_full  = &cur_pending;
   assign hit        = cur_en && (cur_pending != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            enabled_ff[i]  <= 1'b0;
            one_shot_ff[i] <= 1'b0;
         end
      end else begin
         case (ctl.op)
            OP_ARM: begin
               enabled_ff[idx]  <= 1'b1;
               one_shot_ff[idx] <= ctl.one_shot;
            end
            OP_DISABLE: begin
               enabled_ff[idx] <= 1'b0;
            end
            OP_DISPATCH: begin
               if (hit && cur_one_shot) begin
                  enabled_ff[idx] <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // counts carry no reset: they are only read once the slot has been armed
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_TICK: begin
            if (cur_en) begin
               remain_ff[idx] <= fire ? cur_reload : remain_dec;
               if (fire && !pend_full) begin
                  pending_ff[idx] <= cur_pending + {{(COUNT_BITS-1){1'b0}}, 1'b1};
               end
            end
         end
         OP_ARM: begin
            reload_ff[idx]  <= interval;
            remain_ff[idx]  <= interval;
            pending_ff[idx] <= '0;
         end
         OP_DISPATCH: begin
            if (hit) begin
               pending_ff[idx] <= cur_pending - {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/core/ptss_ctrl.sv */
// ----------------------------------------------------------------------------
// ptss_ctrl: command sequencer
// Latches a command word, walks the slot index for tick and dispatch, and
// reports the finished item with its grant.
// ----------------------------------------------------------------------------
module ptss_ctrl import ptss_pkg::*; #(
   parameter int SLOTS = 8,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              hit,
   output logic              busy,
   output logic [IDX_W-1:0]  idx,
   output unit_ctl_type      ctl,
   output done_type          done
);

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic             in_range_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             in_range;
   logic             last;
   logic             finish;
   logic             granted;

   assign in_range = (32'(req_slot) < 32'(SLOTS));
   assign last     = (idx_ff == IDX_W'(SLOTS - 1));
   assign busy     = (state_ff != ST_IDLE);
   assign idx      = idx_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl     = '{op: OP_NONE, one_shot: 1'b0};
      finish  = 1'b0;
      granted = 1'b0;
      idx_in  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            // arm and disable address one slot; tick and dispatch sweep from slot 0
            if (req_cmd inside {CMD_ARM_PERIODIC, CMD_ARM_ONE_SHOT, CMD_DISABLE} && in_range)
            begin
               idx_in = IDX_W'(req_slot);
            end else begin
               idx_in = '0;
            end
         end
         ST_RUN: begin
            case (cmd_ff)
               CMD_TICK: begin
                  ctl.op = OP_TICK;
                  finish = last;
                  idx_in = idx_ff + IDX_W'(1);
               end
               CMD_ARM_PERIODIC: begin
                  ctl.op = in_range_ff ? OP_ARM : OP_NONE;
                  finish = 1'b1;
               end
               CMD_ARM_ONE_SHOT: begin
                  ctl.op       = in_range_ff ? OP_ARM : OP_NONE;
                  ctl.one_shot = 1'b1;
                  finish       = 1'b1;
               end
               CMD_DISABLE: begin
                  ctl.op = in_range_ff ? OP_DISABLE : OP_NONE;
                  finish = 1'b1;
               end
               CMD_DISPATCH: begin
                  ctl.op  = OP_DISPATCH;
                  finish  = hit || last;
                  granted = hit;
                  idx_in  = idx_ff + IDX_W'(1);
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign done.valid   = finish;
   assign done.granted = granted;
   assign done.slot    = granted ? SLOT_W'(idx_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (state_ff == ST_IDLE && start) begin
         cmd_ff      <= cmd_type'(req_cmd);
         in_range_ff <= in_range;
      end
   end

endmodule

/* rtl/core/periodic_task_slot_scheduler.sv */
// Sequence: tick walks every slot from slot 0 before it responds; dispatch walks
//   from slot 0 and stops at the first grant or the last slot; arm and disable touch one slot.
// Handshake: one command word at a time; busy is high from acceptance
//   until the response is registered; the update unit handles one slot per cycle.
// Reset: synchronous, active high; clears the sequencer state, slot enables and rsp_valid.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler: tick-driven task slot scheduler
// A sequencer walks the slots through one shared decrement/compare unit.
// Tick advances every enabled countdown, dispatch grants the lowest enabled
// slot with pending work, arm and disable touch a single slot.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler import ptss_pkg::*; #(
   parameter int SLOTS      = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [IVAL_W-1:0] req_interval_ticks,
   output logic              rsp_valid,
   output logic              rsp_granted,
   output logic [SLOT_W-1:0] rsp_granted_slot
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [COUNT_BITS-1:0] interval_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_granted_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;

   logic [IDX_W-1:0]      idx;
   unit_ctl_type          ctl;
   done_type              done;
   logic                  hit;

   // Sequencer: owns the command word and the slot index.
   ptss_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_cmd  (req_cmd),
      .req_slot (req_slot),
      .hit      (hit),
      .busy     (busy),
      .idx      (idx),
      .ctl      (ctl),
      .done     (done)
   );

   // Slot state and the shared update unit.
   ptss_slot_file #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_slot_file (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .idx      (idx),
      .interval (interval_ff),
      .hit      (hit)
   );

   // Hold the interval for the arm step; mask or widen to the count width.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         interval_ff <= COUNT_BITS'(req_interval_ticks);
      end
   end

   // Register the response; strobe for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_granted_ff <= done.granted;
         rsp_slot_ff    <= done.slot;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule

/* rtl/core/ptss_checker.sv */
// ----------------------------------------------------------------------------
// ptss_checker: port-level checks for the task slot scheduler
// Watches the command and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ptss_checker import ptss_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_granted,
   input logic [SLOT_W-1:0] rsp_granted_slot
);

   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // the response strobe lasts one cycle only
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // every response follows a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a preceding busy cycle");

   // leaving busy always delivers a response
   a_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a response");

   // no grant reports slot zero
   a_nogrant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_granted_slot == '0)
      else $error("slot reported without a grant");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_granted      (rsp_granted),
   .rsp_granted_slot (rsp_granted_slot)
);

/* dv/periodic_task_slot_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_test: self-checking bench for the slot scheduler
// Drives command words through the start/busy handshake and keeps its own
// model of every slot's countdown and pending count. Each strobed response is
// compared with the grant that this model predicts, or with the grant pinned in
// the table row. The run has a directed table, a run of back-to-back ticks that
// builds a deep pending count, and a random mix.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_test;
   import ptss_pkg::*;

   localparam int SLOT_COUNT = 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = SLOT_COUNT + 4;
   localparam int NUM_ROWS = 25;
   localparam int RANDOM_WORDS = 750;
   localparam int LONG_TICKS = 200;

   // Command codes that the block must ignore
   localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

   localparam logic [IVAL_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot;
   } grant_type;

   // One row of the directed table. Where pinned is set, the grant in the
   // row is the expectation; otherwise the slot model supplies it.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] slot;
      logic [IVAL_W-1:0] ival;
      logic              pinned;
      logic              granted;
      logic [SLOT_W-1:0] gslot;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd;
   logic [SLOT_W-1:0] req_slot;
   logic [IVAL_W-1:0] req_interval_ticks;
   logic              rsp_valid;
   logic              rsp_granted;
   logic [SLOT_W-1:0] rsp_granted_slot;

   // Pinned expectation travels with the word it belongs to
   logic              drv_pinned;
   logic              drv_granted;
   logic [SLOT_W-1:0] drv_gslot;

   // Slot model state
   logic              sched_enabled   [SLOT_COUNT];
   logic              sched_one_shot  [SLOT_COUNT];
   logic [IVAL_W-1:0] sched_reload    [SLOT_COUNT];
   logic [IVAL_W-1:0] sched_remaining [SLOT_COUNT];
   logic [IVAL_W-1:0] sched_pending   [SLOT_COUNT];

   grant_type grants_due [$];
   grant_type want;
   grant_type got;

   int errors = 0;
   int words_accepted = 0;
   int grants_seen = 0;
   int cycle_count = 0;
   int k;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // after reset nothing is pending
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      // reserved codes change nothing
      '{CMD_RSVD_A,       3'd3, 16'hFFFF, 1'b1, 1'b0, 3'd0},
      '{CMD_RSVD_B,       3'd4, 16'h0000, 1'b1, 1'b0, 3'd0},
      '{CMD_RSVD_C,       3'd7, 16'hAAAA, 1'b1, 1'b0, 3'd0},
      '{CMD_DISABLE,      3'd2, 16'h0000, 1'b1, 1'b0, 3'd0},
      // slot 7 every tick, slot 0 once after two ticks
      '{CMD_ARM_PERIODIC, 3'd7, 16'h0001, 1'b1, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      '{CMD_ARM_ONE_SHOT, 3'd0, 16'h0002, 1'b1, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      // lowest slot wins, and the one-shot drops out once served
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b1, 1'b1, 3'd0},
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b1, 1'b1, 3'd7},
      // a disabled slot keeps its count but is never granted
      '{CMD_DISABLE,      3'd7, 16'h0000, 1'b1, 1'b0, 3'd0},
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      // re-arming clears the count
      '{CMD_ARM_PERIODIC, 3'd7, 16'hFFFF, 1'b0, 1'b0, 3'd0},
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
      // zero interval means a full wrap of the countdown
      '{CMD_ARM_PERIODIC, 3'd3, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_ARM_ONE_SHOT, 3'd5, 16'h0003, 1'b0, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_TICK,         3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_DISPATCH,     3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
      '{CMD_ARM_PERIODIC, 3'd6, 16'h5555, 1'b0, 1'b0, 3'd0}
   };

   periodic_task_slot_scheduler #(
      .SLOTS      (SLOT_COUNT),
      .COUNT_BITS (IVAL_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_interval_ticks (req_interval_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_granted_slot   (rsp_granted_slot)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the slot model by one command word and return the grant it gives.
   function automatic grant_type next_grant(input logic [CMD_W-1:0] cmd,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [IVAL_W-1:0] ival);
      grant_type g;
      int i;
      g = '0;
      case (cmd)
         CMD_TICK: begin
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (sched_enabled[i]) begin
                  // countdown wraps, so a zero reload waits a full 2^16 ticks
                  sched_remaining[i] = sched_remaining[i] - 1'b1;
                  if (sched_remaining[i] == '0) begin
                     sched_remaining[i] = sched_reload[i];
                     if (sched_pending[i] != COUNT_MAX)
                        sched_pending[i] = sched_pending[i] + 1'b1;
                  end
               end
            end
         end
         CMD_ARM_PERIODIC, CMD_ARM_ONE_SHOT: begin
            sched_enabled[slot]   = 1'b1;
            sched_one_shot[slot]  = (cmd == CMD_ARM_ONE_SHOT);
            sched_reload[slot]    = ival;
            sched_remaining[slot] = ival;
            sched_pending[slot]   = '0;
         end
         CMD_DISABLE: sched_enabled[slot] = 1'b0;
         CMD_DISPATCH: begin
            for (i = 0; i < SLOT_COUNT && !g.granted; i++) begin
               if (sched_enabled[i] && sched_pending[i] != '0) begin
                  sched_pending[i] = sched_pending[i] - 1'b1;
                  if (sched_one_shot[i])
                     sched_enabled[i] = 1'b0;
                  g.granted = 1'b1;
                  g.slot = SLOT_W'(i);
               end
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   // Check responses first, then log any word accepted on the same edge;
   // the response on this edge always belongs to an older word.
   always @(posedge clock) begin
      if (reset) begin
         for (k = 0; k < SLOT_COUNT; k++) begin
            sched_enabled[k]   = 1'b0;
            sched_one_shot[k]  = 1'b0;
            sched_reload[k]    = '0;
            sched_remaining[k] = '0;
            sched_pending[k]   = '0;
         end
      end else begin
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               $error("response with nothing outstanding: granted %0d slot %0d",
                      rsp_granted, rsp_granted_slot);
               errors++;
            end else begin
               want = grants_due.pop_front();
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_granted);
                  errors++;
               end
               if (rsp_granted_slot !== want.slot) begin
                  $error("granted_slot: expected %0d, got %0d",
                         want.slot, rsp_granted_slot);
                  errors++;
               end
               if (rsp_granted === 1'b1)
                  grants_seen++;
            end
         end
         if (start && !busy) begin
            got = next_grant(req_cmd, req_slot, req_interval_ticks);
            if (drv_pinned) begin
               got.granted = drv_granted;
               got.slot = drv_gslot;
            end
            grants_due.push_back(got);
            words_accepted++;
         end
      end
   end

   // Watchdog: the slowest legal run is well under this
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one word and hold it until the block takes it. Start stays high
   // on return so that a following word goes out back to back.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [IVAL_W-1:0] ival, input logic pinned,
                            input logic granted, input logic [SLOT_W-1:0] gslot);
      start <= 1'b1;
      req_cmd <= cmd;
      req_slot <= slot;
      req_interval_ticks <= ival;
      drv_pinned <= pinned;
      drv_granted <= granted;
      drv_gslot <= gslot;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait for every outstanding response; step one edge first
   // so that a word taken on the current edge is already logged
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (grants_due.size() != 0)
         @(posedge clock);
   endtask

   // Mostly back to back, sometimes a short gap, now and then a long one
   task automatic random_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r >= 11 && r < 18)
         hold_off($urandom_range(1, 3));
      else if (r >= 18)
         hold_off($urandom_range(15, 60));
   endtask

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [IVAL_W-1:0] ival;
      int r;
      int n;

      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_TICK;
      req_slot <= '0;
      req_interval_ticks <= '0;
      drv_pinned <= 1'b0;
      drv_granted <= 1'b0;
      drv_gslot <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (n = 0; n < NUM_ROWS; n++) begin
         send_word(directed_rows[n].cmd, directed_rows[n].slot, directed_rows[n].ival,
                   directed_rows[n].pinned, directed_rows[n].granted,
                   directed_rows[n].gslot);
         random_gap();
      end

      // Tick run: slot 0 fires every tick and builds a deep pending count;
      // slot 1 has a zero interval, wraps its countdown on the first tick and
      // must stay silent for the whole run. Run back to back.
      drain();
      for (n = 2; n < SLOT_COUNT; n++)
         send_word(CMD_DISABLE, SLOT_W'(n), '0, 1'b0, 1'b0, '0);
      send_word(CMD_ARM_PERIODIC, 3'd1, 16'h0000, 1'b0, 1'b0, '0);
      send_word(CMD_ARM_PERIODIC, 3'd0, 16'h0001, 1'b0, 1'b0, '0);
      for (n = 0; n < LONG_TICKS; n++)
         send_word(CMD_TICK, '0, '0, 1'b0, 1'b0, '0);
      // slot 0 keeps winning; once it is disabled slot 1 has nothing pending
      repeat (6) send_word(CMD_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
      send_word(CMD_DISABLE, 3'd0, '0, 1'b0, 1'b0, '0);
      repeat (3) send_word(CMD_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
      drain();

      // Random mix, weighted towards ticks and dispatches on short intervals
      // so that slots fire often and grants are common
      for (n = 0; n < RANDOM_WORDS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 38)
            cmd = CMD_TICK;
         else if (r < 66)
            cmd = CMD_DISPATCH;
         else if (r < 76)
            cmd = CMD_ARM_PERIODIC;
         else if (r < 84)
            cmd = CMD_ARM_ONE_SHOT;
         else if (r < 93)
            cmd = CMD_DISABLE;
         else
            cmd = CMD_RSVD_A + CMD_W'($urandom_range(0, 2));
         r = $urandom_range(0, 9);
         if (r < 6)
            ival = IVAL_W'($urandom_range(1, 4));
         else if (r == 6)
            ival = '0;
         else if (r == 7)
            ival = COUNT_MAX;
         else
            ival = IVAL_W'($urandom_range(0, 65535));
         send_word(cmd, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), ival,
                   1'b0, 1'b0, '0);
         if ($urandom_range(0, 99) == 0)
            drain();
         else
            random_gap();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d command words, %0d of them granted dispatches,",
               words_accepted, grants_seen);
      $display("including a deep pending count, zero intervals and reserved codes.");
      if (errors == 0 && grants_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (grants_due.size() != 0)
            $error("%0d responses never arrived", grants_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ptss_pkg.sv
rtl/core/ptss_slot_file.sv
rtl/core/ptss_ctrl.sv
rtl/core/periodic_task_slot_scheduler.sv
rtl/core/ptss_checker.sv
dv/periodic_task_slot_scheduler_test.sv
